>>> rtl/lru_tub_pkg.sv
// shared types and constants for the texture unit binder
// no dependencies
`timescale 1ns / 1ps

package lru_tub_pkg;

    localparam int ID_W            = 16;
    localparam int UNIT_OUT_W      = 3;
    localparam int UNIT_COUNT_DEF  = 8;

    // request kinds
    localparam logic KIND_BIND   = 1'b0;
    localparam logic KIND_UNBIND = 1'b1;

    // operation applied to the tables in the cycle a request resolves
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_TAKE,
        OP_EVICT,
        OP_RELEASE
    } upd_op_t;

    typedef struct packed {
        upd_op_t           op;
        logic [ID_W-1:0]   id;
    } upd_t;

endpackage

>>> rtl/lru_texture_unit_binder_core.sv
// top level of the texture unit binder: request register, decision, result register
// depends on lru_tub_pkg, lru_tub_owner, lru_tub_recency, lru_tub_free_stack
`timescale 1ns / 1ps

// Binds texture ids to a pool of UNIT_COUNT texture units. A request (bind or
// unbind) is taken on any cycle with start high; busy is never raised, so one
// request per clock is sustained. Each request gives exactly one result, shown
// with done high for a single cycle: the request is taken into the request
// register, then passes through the owner match, list reorder and free stack
// update into the result register. Table updates land in the
// same edge as the result, so back-to-back requests on the same texture see
// each other. The receiver cannot stall results; it must sample on done.

module lru_texture_unit_binder_core
    import lru_tub_pkg::*;
#(
    parameter int UNIT_COUNT = UNIT_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [ID_W-1:0]       texture_id,
    output logic                  done,
    output logic [UNIT_OUT_W-1:0] unit,
    output logic                  hit,
    output logic                  evicted,
    output logic [ID_W-1:0]       evicted_texture,
    output logic                  released
);

    localparam int UW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int CW = $clog2(UNIT_COUNT + 1);

    logic                  req_valid_reg;
    logic                  req_kind_reg;
    logic [ID_W-1:0]       req_id_reg;

    logic                  own_hit;
    logic [UW-1:0]         hit_unit;
    logic [UW-1:0]         lru_unit;
    logic [ID_W-1:0]       lru_owner;
    logic [UW-1:0]         free_top;
    logic                  free_empty;

    upd_t                  upd;
    logic [UW-1:0]         sel_unit;
    logic [UW+UNIT_OUT_W-1:0] sel_unit_ext;

    logic                  done_reg;
    logic [UNIT_OUT_W-1:0] unit_reg;
    logic                  hit_reg;
    logic                  evicted_reg;
    logic [ID_W-1:0]       evtex_reg;
    logic                  released_reg;

    assign busy = 1'b0;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_kind_reg <= kind;
            req_id_reg   <= texture_id;
        end
    end

    // table units
    lru_tub_owner #(
        .UNIT_COUNT (UNIT_COUNT),
        .UW         (UW)
    ) u_owner (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_id       (req_id_reg),
        .lookup_unit  (lru_unit),
        .upd          (upd),
        .upd_unit     (sel_unit),
        .hit          (own_hit),
        .hit_unit     (hit_unit),
        .lookup_owner (lru_owner)
    );

    lru_tub_recency #(
        .UNIT_COUNT (UNIT_COUNT),
        .UW         (UW),
        .CW         (CW)
    ) u_recency (
        .clk      (clk),
        .rst_n    (rst_n),
        .hit_unit (hit_unit),
        .upd      (upd),
        .upd_unit (sel_unit),
        .lru_unit (lru_unit)
    );

    lru_tub_free_stack #(
        .UNIT_COUNT (UNIT_COUNT),
        .UW         (UW),
        .CW         (CW)
    ) u_free (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .upd_unit   (sel_unit),
        .free_top   (free_top),
        .free_empty (free_empty)
    );

    // choose the operation and the unit it acts on
    always_comb
    begin
        upd.id   = req_id_reg;
        upd.op   = OP_NONE;
        sel_unit = '0;
        if (req_valid_reg && (req_id_reg != '0))
        begin
            if (req_kind_reg == KIND_BIND)
            begin
                priority if (own_hit)
                begin
                    upd.op   = OP_HIT;
                    sel_unit = hit_unit;
                end
                else if (!free_empty)
                begin
                    upd.op   = OP_TAKE;
                    sel_unit = free_top;
                end
                else
                begin
                    upd.op   = OP_EVICT;
                    sel_unit = lru_unit;
                end
            end
            else if (own_hit)
            begin
                upd.op   = OP_RELEASE;
                sel_unit = hit_unit;
            end
        end
    end

    // unit reported on its three-bit field
    assign sel_unit_ext = {{UNIT_OUT_W{1'b0}}, sel_unit};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg     <= sel_unit_ext[UNIT_OUT_W-1:0];
        hit_reg      <= (upd.op == OP_HIT);
        evicted_reg  <= (upd.op == OP_EVICT);
        evtex_reg    <= (upd.op == OP_EVICT) ? lru_owner : '0;
        released_reg <= (upd.op == OP_RELEASE);
    end

    assign done            = done_reg;
    assign unit            = unit_reg;
    assign hit             = hit_reg;
    assign evicted         = evicted_reg;
    assign evicted_texture = evtex_reg;
    assign released        = released_reg;

endmodule

>>> rtl/lru_tub_owner.sv
// owner table: texture id held by each unit, parallel id match
// depends on lru_tub_pkg
`timescale 1ns / 1ps

module lru_tub_owner
    import lru_tub_pkg::*;
#(
    parameter int UNIT_COUNT = UNIT_COUNT_DEF,
    parameter int UW         = 3
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [ID_W-1:0] req_id,
    input  logic [UW-1:0]   lookup_unit,
    input  upd_t            upd,
    input  logic [UW-1:0]   upd_unit,
    output logic            hit,
    output logic [UW-1:0]   hit_unit,
    output logic [ID_W-1:0] lookup_owner
);

    logic [ID_W-1:0]       owner_reg [UNIT_COUNT];
    logic [UNIT_COUNT-1:0] match;

    // compare the request id against every owner at once
    always_comb
    begin
        hit_unit = '0;
        for (int i = 0; i < UNIT_COUNT; i++)
        begin
            match[i] = (owner_reg[i] == req_id) && (req_id != '0);
            if (match[i])
            begin
                hit_unit = hit_unit | UW'(i);
            end
        end
        hit          = |match;
        lookup_owner = owner_reg[lookup_unit];
    end

    // owner updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < UNIT_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (upd.op)
                OP_HIT, OP_TAKE, OP_EVICT: owner_reg[upd_unit] <= upd.id;
                OP_RELEASE:                owner_reg[upd_unit] <= '0;
                default:                   ;
            endcase
        end
    end

endmodule

>>> rtl/lru_tub_recency.sv
// recency list of units in use, most recent at position zero
// depends on lru_tub_pkg
`timescale 1ns / 1ps

module lru_tub_recency
    import lru_tub_pkg::*;
#(
    parameter int UNIT_COUNT = UNIT_COUNT_DEF,
    parameter int UW         = 3,
    parameter int CW         = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [UW-1:0] hit_unit,
    input  upd_t          upd,
    input  logic [UW-1:0] upd_unit,
    output logic [UW-1:0] lru_unit
);

    logic [UW-1:0] rec_reg  [UNIT_COUNT];
    logic [UW-1:0] rec_next [UNIT_COUNT];
    logic [CW-1:0] used_reg;
    logic [CW-1:0] used_next;
    logic [CW-1:0] used_m1;
    logic [CW-1:0] hit_pos;
    logic [CW-1:0] ins_pos;

    assign used_m1  = used_reg - CW'(1);
    assign lru_unit = rec_reg[used_m1[UW-1:0]];

    // position of the hit unit within the live part of the list
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < UNIT_COUNT; i++)
        begin
            if ((rec_reg[i] == hit_unit) && (CW'(i) < used_reg))
            begin
                hit_pos = hit_pos | CW'(i);
            end
        end
    end

    // deepest position that shifts down when a unit goes to the front
    always_comb
    begin
        unique case (upd.op)
            OP_HIT:  ins_pos = hit_pos;
            OP_TAKE: ins_pos = used_reg;
            default: ins_pos = used_m1;
        endcase
    end

    // list reorder
    always_comb
    begin
        used_next = used_reg;
        for (int i = 0; i < UNIT_COUNT; i++)
        begin
            rec_next[i] = rec_reg[i];
        end
        unique case (upd.op)
            OP_HIT, OP_TAKE, OP_EVICT:
            begin
                rec_next[0] = upd_unit;
                for (int i = 1; i < UNIT_COUNT; i++)
                begin
                    if (CW'(i) <= ins_pos)
                    begin
                        rec_next[i] = rec_reg[i-1];
                    end
                end
                if (upd.op == OP_TAKE)
                begin
                    used_next = used_reg + CW'(1);
                end
            end
            OP_RELEASE:
            begin
                for (int i = 0; i < UNIT_COUNT - 1; i++)
                begin
                    if (CW'(i) >= hit_pos)
                    begin
                        rec_next[i] = rec_reg[i+1];
                    end
                end
                used_next = used_m1;
            end
            default: ;
        endcase
    end

    // list contents are meaningful only below the use count
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < UNIT_COUNT; i++)
        begin
            rec_reg[i] <= rec_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

>>> rtl/lru_tub_free_stack.sv
// stack of free units with its fill count
// depends on lru_tub_pkg
`timescale 1ns / 1ps

module lru_tub_free_stack
    import lru_tub_pkg::*;
#(
    parameter int UNIT_COUNT = UNIT_COUNT_DEF,
    parameter int UW         = 3,
    parameter int CW         = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  upd_t          upd,
    input  logic [UW-1:0] upd_unit,
    output logic [UW-1:0] free_top,
    output logic          free_empty
);

    logic [UW-1:0] fs_reg [UNIT_COUNT];
    logic [CW-1:0] free_cnt_reg;

    assign free_top   = fs_reg[0];
    assign free_empty = (free_cnt_reg == '0);

    // pop on take, push on release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < UNIT_COUNT; i++)
            begin
                fs_reg[i] <= UW'(i);
            end
            free_cnt_reg <= CW'(UNIT_COUNT);
        end
        else
        begin
            unique case (upd.op)
                OP_TAKE:
                begin
                    for (int i = 0; i < UNIT_COUNT - 1; i++)
                    begin
                        fs_reg[i] <= fs_reg[i+1];
                    end
                    free_cnt_reg <= free_cnt_reg - CW'(1);
                end
                OP_RELEASE:
                begin
                    fs_reg[0] <= upd_unit;
                    for (int i = 1; i < UNIT_COUNT; i++)
                    begin
                        fs_reg[i] <= fs_reg[i-1];
                    end
                    free_cnt_reg <= free_cnt_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/lru_tub_checker.sv
// port-level checks for the texture unit binder, bound to the top level
// depends on lru_tub_pkg and lru_texture_unit_binder_core
`timescale 1ns / 1ps

module lru_tub_checker
    import lru_tub_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  kind,
    input  logic                  done,
    input  logic                  hit,
    input  logic                  evicted,
    input  logic [ID_W-1:0]       evicted_texture,
    input  logic                  released
);

    // every accepted request gives a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without request");

    // at most one outcome flag per result
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({hit, evicted, released}))
        else $error("conflicting outcome flags");

    // a stolen unit always had an owner, and only theft names one
    a_evtex_owner: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (evicted == (evicted_texture != '0)))
        else $error("evicted texture inconsistent with evicted flag");

    // released only answers an unbind request
    a_release_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_BIND)) |-> ##2 !released)
        else $error("release reported for a bind request");

endmodule

bind lru_texture_unit_binder_core lru_tub_checker u_lru_tub_checker (.*);
